/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl files of the lockout block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/fbl_pkg.sv */
// types and constants of the failure backoff lockout block
package fbl_pkg;

    localparam int TS_W       = 64;
    localparam int WIN_W      = 40;
    localparam int CNT_W      = 16;
    localparam int MS_W       = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int MAX_SLOTS  = 4;
    localparam int DEF_SLOTS  = 4;

    typedef enum logic [1:0] {
        CMD_CHECK   = 2'd0,
        CMD_FAIL    = 2'd1,
        CMD_SUCCESS = 2'd2
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP0  = 3'd2;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 40'd43200000000;
    localparam logic [CNT_W-1:0] LIMIT_RESET  = 16'd5;
    localparam logic [MS_W-1:0]  STEP_RESET [MAX_SLOTS] = '{
        32'd1000, 32'd5000, 32'd30000, 32'd300000
    };

    // microseconds to milliseconds: shift by 3, then multiply by ceil(2^68 / 125)
    localparam int US_PER_MS   = 1000;
    localparam int PRE_SHIFT   = 3;
    localparam int SCALED_DIV  = US_PER_MS >> PRE_SHIFT;
    localparam int RECIP_SHIFT = 68;
    localparam int Y_W         = TS_W - PRE_SHIFT;
    localparam logic [127:0] RECIP_FULL =
        ((128'd1 << RECIP_SHIFT) + 128'(SCALED_DIV) - 128'd1) / 128'(SCALED_DIV);
    localparam logic [31:0] RECIP_LO = RECIP_FULL[31:0];
    localparam logic [29:0] RECIP_HI = RECIP_FULL[61:32];
    localparam int Q_LSB = RECIP_SHIFT - 32;

    typedef struct packed {
        logic             lock;
        logic [CNT_W-1:0] tally;
        logic [TS_W-1:0]  now;
        logic [TS_W-1:0]  last;
    } fbl_event_t;

    typedef struct packed {
        logic             lock;
        logic [CNT_W-1:0] tally;
    } fbl_side_t;

endpackage

/* rtl/core/failure_backoff_lockout.sv */
// Failure backoff with hard lockout. Takes one event item per clock cycle, sustained,
// and presents one result item per event once it has passed the input register and the
// pipeline stages. The rate is set by the state update (expiry, window, count and lock),
// which is combinational and is registered as an item leaves the input register; the
// microsecond to millisecond conversion behind it is pipelined over the following stages.
// Output stalls back up through the stages and the input register without losing items.
module failure_backoff_lockout
    import fbl_pkg::*;
#(
    parameter int BACKOFF_SLOTS = DEF_SLOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic [TS_W-1:0]       now_us,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  locked_out,
    output logic [MS_W-1:0]       backoff_remaining_ms,
    output logic [CNT_W-1:0]      failures_so_far,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    `include "assert_macros.svh"

    logic [WIN_W-1:0] window_reg;
    logic [CNT_W-1:0] limit_reg;
    logic [MS_W-1:0]  step_reg [BACKOFF_SLOTS];

    logic             v0_reg;
    logic [1:0]       cmd0_reg;
    logic [TS_W-1:0]  now0_reg;

    logic [CNT_W-1:0] tally_reg, tally_next;
    logic [TS_W-1:0]  window_start_reg, window_start_next;
    logic [TS_W-1:0]  last_fail_reg, last_fail_next;
    logic             lock_reg, lock_next;
    logic [TS_W-1:0]  lock_start_reg, lock_start_next;

    logic             pipe_ready;
    logic             handoff;
    logic [TS_W-1:0]  win64;
    fbl_event_t       event_next;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            limit_reg  <= LIMIT_RESET;
            for (int i = 0; i < BACKOFF_SLOTS; i++)
            begin
                step_reg[i] <= STEP_RESET[i];
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WINDOW: window_reg <= cfg_data[WIN_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_data[CNT_W-1:0];
                default:
                begin
                    for (int i = 0; i < BACKOFF_SLOTS; i++)
                    begin
                        if (cfg_index == CFG_IDX_W'(int'(REG_STEP0) + i))
                        begin
                            step_reg[i] <= cfg_data[MS_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    // input register
    assign in_ready = !v0_reg || pipe_ready;
    assign handoff  = v0_reg && pipe_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd0_reg <= command;
            now0_reg <= now_us;
        end
    end

    // state update: expiry, command, expiry again
    assign win64 = TS_W'(window_reg);

    always_comb
    begin
        tally_next        = tally_reg;
        window_start_next = window_start_reg;
        last_fail_next    = last_fail_reg;
        lock_next         = lock_reg;
        lock_start_next   = lock_start_reg;

        if (lock_next && (now0_reg - lock_start_next) >= win64)
        begin
            tally_next        = '0;
            window_start_next = '0;
            last_fail_next    = '0;
            lock_next         = 1'b0;
            lock_start_next   = '0;
        end

        case (cmd0_reg)
            CMD_FAIL:
            begin
                if (window_start_next == '0 || (now0_reg - window_start_next) >= win64)
                begin
                    window_start_next = now0_reg;
                    tally_next        = '0;
                end
                if (tally_next != '1)
                begin
                    tally_next = tally_next + 1'b1;
                end
                last_fail_next = now0_reg;
                if (tally_next >= limit_reg)
                begin
                    lock_next       = 1'b1;
                    lock_start_next = now0_reg;
                end
            end
            CMD_SUCCESS:
            begin
                tally_next        = '0;
                window_start_next = '0;
                last_fail_next    = '0;
                lock_next         = 1'b0;
                lock_start_next   = '0;
            end
            default:
            begin
                tally_next = tally_next;
            end
        endcase

        if (lock_next && (now0_reg - lock_start_next) >= win64)
        begin
            tally_next        = '0;
            window_start_next = '0;
            last_fail_next    = '0;
            lock_next         = 1'b0;
            lock_start_next   = '0;
        end

        event_next.lock  = lock_next;
        event_next.tally = tally_next;
        event_next.now   = now0_reg;
        event_next.last  = last_fail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg        <= '0;
            window_start_reg <= '0;
            last_fail_reg    <= '0;
            lock_reg         <= 1'b0;
            lock_start_reg   <= '0;
        end
        else if (handoff)
        begin
            tally_reg        <= tally_next;
            window_start_reg <= window_start_next;
            last_fail_reg    <= last_fail_next;
            lock_reg         <= lock_next;
            lock_start_reg   <= lock_start_next;
        end
    end

    fbl_backoff_pipe #(
        .BACKOFF_SLOTS (BACKOFF_SLOTS)
    ) u_pipe (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (v0_reg),
        .in_ready             (pipe_ready),
        .in_event             (event_next),
        .steps                (step_reg),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .locked_out           (locked_out),
        .backoff_remaining_ms (backoff_remaining_ms),
        .failures_so_far      (failures_so_far)
    );

    `ASSERT_CLK(a_lock_has_count, lock_reg |-> tally_reg != '0, "lockout with zero failure count")
    `ASSERT_CLK(a_state_holds, !handoff |=> $stable(tally_reg) && $stable(lock_reg) && $stable(window_start_reg), "state changed without an item")
    `ASSERT_CLK(a_s0_holds, v0_reg && !pipe_ready |=> v0_reg && $stable(now0_reg) && $stable(cmd0_reg), "stalled input register changed")

endmodule

/* rtl/core/fbl_backoff_pipe.sv */
// pipeline that turns the updated state of one item into its result
module fbl_backoff_pipe
    import fbl_pkg::*;
#(
    parameter int BACKOFF_SLOTS = DEF_SLOTS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fbl_event_t       in_event,
    input  logic [MS_W-1:0]  steps [BACKOFF_SLOTS],
    output logic             out_valid,
    input  logic             out_ready,
    output logic             locked_out,
    output logic [MS_W-1:0]  backoff_remaining_ms,
    output logic [CNT_W-1:0] failures_so_far
);

    `include "assert_macros.svh"

    localparam int SLOT_IDX_W = (BACKOFF_SLOTS > 1) ? $clog2(BACKOFF_SLOTS) : 1;
    localparam int STAGES     = 6;

    logic [STAGES:1] v_reg;
    logic [STAGES:1] rdy;
    logic [STAGES:1] stage_in;

    fbl_event_t       s1_reg;
    fbl_side_t        side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;
    logic [Y_W-1:0]   y2_reg;
    logic [MS_W-1:0]  need2_reg, need3_reg, need4_reg, need5_reg;
    logic [63:0]      p_ll3_reg;
    logic [61:0]      p_lh3_reg;
    logic [60:0]      p_hl3_reg;
    logic [58:0]      p_hh3_reg;
    logic [31:0]      ll_hi4_reg;
    logic [62:0]      mid4_reg;
    logic [58:0]      hh4_reg;
    logic [MS_W-1:0]  q5_reg;
    logic [MS_W-1:0]  backoff6_reg;

    logic [TS_W-1:0]       elapsed_us;
    logic [CNT_W-1:0]      tally_m1;
    logic [SLOT_IDX_W-1:0] slot_idx;
    logic [MS_W-1:0]       need_next;
    logic [RECIP_SHIFT-1:0] upper_sum;
    logic [MS_W-1:0]       backoff_next;

    // stage handshake
    always_comb
    begin
        rdy[STAGES] = !v_reg[STAGES] || out_ready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        stage_in = {v_reg[STAGES-1:1], in_valid};
    end

    assign in_ready = rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= STAGES; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= stage_in[k];
                end
            end
        end
    end

    // elapsed time and the step for the current count
    always_comb
    begin
        elapsed_us = (s1_reg.now > s1_reg.last) ? (s1_reg.now - s1_reg.last) : '0;
        tally_m1   = s1_reg.tally - 1'b1;
        if (s1_reg.tally >= CNT_W'(BACKOFF_SLOTS))
        begin
            slot_idx = SLOT_IDX_W'(BACKOFF_SLOTS - 1);
        end
        else
        begin
            slot_idx = tally_m1[SLOT_IDX_W-1:0];
        end
        need_next = (s1_reg.tally == '0) ? '0 : steps[slot_idx];
    end

    // product is split in 32 bit halves, upper part summed for quotient bits; backoff is the step less the quotient
    always_comb
    begin
        upper_sum = RECIP_SHIFT'(ll_hi4_reg) + RECIP_SHIFT'(mid4_reg)
                  + {hh4_reg[RECIP_SHIFT-33:0], 32'b0};
        backoff_next = (q5_reg >= need5_reg) ? '0 : (need5_reg - q5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1] && stage_in[1])
        begin
            s1_reg <= in_event;
        end
        if (rdy[2] && stage_in[2])
        begin
            y2_reg    <= elapsed_us[TS_W-1:PRE_SHIFT];
            need2_reg <= need_next;
            side2_reg <= '{lock: s1_reg.lock, tally: s1_reg.tally};
        end
        if (rdy[3] && stage_in[3])
        begin
            p_ll3_reg <= 64'(y2_reg[31:0]) * 64'(RECIP_LO);
            p_lh3_reg <= 62'(y2_reg[31:0]) * 62'(RECIP_HI);
            p_hl3_reg <= 61'(y2_reg[Y_W-1:32]) * 61'(RECIP_LO);
            p_hh3_reg <= 59'(y2_reg[Y_W-1:32]) * 59'(RECIP_HI);
            need3_reg <= need2_reg;
            side3_reg <= side2_reg;
        end
        if (rdy[4] && stage_in[4])
        begin
            ll_hi4_reg <= p_ll3_reg[63:32];
            mid4_reg   <= 63'(p_lh3_reg) + 63'(p_hl3_reg);
            hh4_reg    <= p_hh3_reg;
            need4_reg  <= need3_reg;
            side4_reg  <= side3_reg;
        end
        if (rdy[5] && stage_in[5])
        begin
            q5_reg    <= upper_sum[Q_LSB+MS_W-1:Q_LSB];
            need5_reg <= need4_reg;
            side5_reg <= side4_reg;
        end
        if (rdy[6] && stage_in[6])
        begin
            backoff6_reg <= backoff_next;
            side6_reg    <= side5_reg;
        end
    end

    assign out_valid            = v_reg[STAGES];
    assign locked_out           = side6_reg.lock;
    assign failures_so_far      = side6_reg.tally;
    assign backoff_remaining_ms = backoff6_reg;

    `ASSERT_CLK(a_no_count_no_wait, out_valid && failures_so_far == '0 |-> backoff_remaining_ms == '0, "backoff without failures")
    `ASSERT_CLK(a_need_zero, v_reg[2] && side2_reg.tally == '0 |-> need2_reg == '0, "step chosen for zero count")
    `ASSERT_CLK(a_s1_holds, v_reg[1] && !rdy[2] |=> v_reg[1] && $stable(s1_reg), "stalled first stage changed")

endmodule

/* verif/fbl_tb_pkg.sv */
// scoreboard class and codes for the failure backoff lockout testbench
package fbl_tb_pkg;

    import fbl_pkg::*;

    localparam logic [1:0]           CMD_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int                   PRINT_CAP   = 40;
    localparam int                   SLOT_W      = $clog2(MAX_SLOTS);

    typedef struct packed {
        logic             lock;
        logic [MS_W-1:0]  backoff;
        logic [CNT_W-1:0] tally;
    } verdict_t;

    class lockout_ledger;

        logic [WIN_W-1:0] window_len;
        logic [CNT_W-1:0] fail_limit;
        logic [MS_W-1:0]  step_ms [MAX_SLOTS];

        logic [CNT_W-1:0] tally;
        logic [TS_W-1:0]  win_start;
        logic [TS_W-1:0]  last_fail;
        logic [TS_W-1:0]  lock_start;
        bit               locked;

        verdict_t    due_verdicts [$];
        int unsigned faults;
        int unsigned checked;

        function new();
            window_len = WINDOW_RESET;
            fail_limit = LIMIT_RESET;
            foreach (step_ms[i])
                step_ms[i] = STEP_RESET[i];
            clear_state();
            faults  = 0;
            checked = 0;
        endfunction

        function void clear_state();
            tally      = '0;
            win_start  = '0;
            last_fail  = '0;
            lock_start = '0;
            locked     = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_WINDOW)
                window_len = data[WIN_W-1:0];
            else if (idx == REG_LIMIT)
                fail_limit = data[CNT_W-1:0];
            else if (idx >= REG_STEP0 && idx < REG_STEP0 + MAX_SLOTS)
                step_ms[SLOT_W'(idx - REG_STEP0)] = data[MS_W-1:0];
        endfunction

        function void release_if_due(logic [TS_W-1:0] t);
            if (locked && (t - lock_start) >= TS_W'(window_len))
                clear_state();
        endfunction

        function void record_failure(logic [TS_W-1:0] t);
            if (win_start == '0 || (t - win_start) >= TS_W'(window_len))
            begin
                win_start = t;
                tally     = '0;
            end
            if (tally != {CNT_W{1'b1}})
                tally++;
            last_fail = t;
            if (tally >= fail_limit)
            begin
                locked     = 1'b1;
                lock_start = t;
            end
        endfunction

        function logic [MS_W-1:0] backoff_at(logic [TS_W-1:0] t);
            int unsigned      slot;
            logic [MS_W-1:0]  need;
            logic [MS_W-1:0]  gone_ms;
            logic [TS_W-1:0]  gone_us;
            if (tally == '0)
                return '0;
            slot = tally - 1;
            if (slot > DEF_SLOTS - 1)
                slot = DEF_SLOTS - 1;
            need    = step_ms[SLOT_W'(slot)];
            gone_us = (t > last_fail) ? t - last_fail : '0;
            gone_ms = MS_W'(gone_us / US_PER_MS);
            return (gone_ms >= need) ? '0 : need - gone_ms;
        endfunction

        // accepted event item: advance the lockout state and queue its verdict
        function void note_event(logic [1:0] cmd, logic [TS_W-1:0] t);
            verdict_t v;
            release_if_due(t);
            if (cmd == CMD_FAIL)
                record_failure(t);
            else if (cmd == CMD_SUCCESS)
                clear_state();
            release_if_due(t);
            v.lock    = locked;
            v.backoff = backoff_at(t);
            v.tally   = tally;
            due_verdicts.push_back(v);
        endfunction

        task report(string what);
            faults++;
            if (faults <= PRINT_CAP)
                $display("mismatch: %s", what);
        endtask

        task check_verdict(logic lock, logic [MS_W-1:0] backoff, logic [CNT_W-1:0] count);
            verdict_t want;
            if (due_verdicts.size() == 0)
            begin
                report($sformatf("result with nothing pending: lock %0b backoff %0d count %0d",
                                 lock, backoff, count));
                return;
            end
            want = due_verdicts.pop_front();
            if (want.lock !== lock || want.backoff !== backoff || want.tally !== count)
                report($sformatf("result %0d: lock %0b/%0b backoff %0d/%0d count %0d/%0d",
                                 checked, lock, want.lock, backoff, want.backoff,
                                 count, want.tally));
            checked++;
        endtask

    endclass

endpackage

/* verif/tb_failure_backoff_lockout.sv */
// top level testbench of the failure backoff lockout block
module tb_failure_backoff_lockout;

    timeunit 1ns;
    timeprecision 1ps;

    import fbl_pkg::*;
    import fbl_tb_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int HOLD_CYCLES     = 80;
    localparam int HOLD_BURST      = 40;
    localparam int SETTLE_CYCLES   = 12;
    localparam int LIMIT_CYCLES    = 400000;

    logic                  clk                  = 1'b0;
    logic                  rst_n                = 1'b0;
    logic                  in_valid             = 1'b0;
    logic                  in_ready;
    logic [1:0]            command              = CMD_CHECK;
    logic [TS_W-1:0]       now_us               = '0;
    logic                  out_valid;
    logic                  out_ready            = 1'b0;
    logic                  locked_out;
    logic [MS_W-1:0]       backoff_remaining_ms;
    logic [CNT_W-1:0]      failures_so_far;
    logic                  cfg_valid            = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index            = REG_WINDOW;
    logic [CFG_DATA_W-1:0] cfg_data             = '0;

    lockout_ledger ledger = new();

    logic [TS_W-1:0] stamp      = '0;
    int unsigned     sent       = 0;
    int unsigned     tx_max     = 8;
    int unsigned     rx_max     = 8;
    int unsigned     rx_wait    = 0;
    int unsigned     burst_left = 0;
    int unsigned     cycles     = 0;
    int unsigned     hold_asks  = 0;
    int unsigned     hold_seen  = 0;

    failure_backoff_lockout u_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .command              (command),
        .now_us               (now_us),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .locked_out           (locked_out),
        .backoff_remaining_ms (backoff_remaining_ms),
        .failures_so_far      (failures_so_far),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stalls per item, plus a long hold when asked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                ledger.check_verdict(locked_out, backoff_remaining_ms, failures_so_far);
                rx_wait = $urandom_range(0, rx_max);
            end
            if (hold_asks != hold_seen)
            begin
                rx_wait   = HOLD_CYCLES;
                hold_seen = hold_asks;
            end
            if (rx_wait != 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic logic [TS_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TS_W-1:0] span(logic [TS_W-1:0] hi);
        if (hi == '1)
            return rand64();
        return rand64() % (hi + 64'd1);
    endfunction

    // near picks stay around backoff scale, spread picks also hit window edges and jumps
    function automatic logic [TS_W-1:0] next_stamp(bit spread);
        logic [TS_W-1:0] win;
        logic [TS_W-1:0] step_us;
        logic [TS_W-1:0] base;
        int unsigned     pick;
        win     = TS_W'(ledger.window_len);
        step_us = TS_W'(ledger.step_ms[SLOT_W'($urandom_range(0, MAX_SLOTS - 1))]) * US_PER_MS;
        base    = ledger.locked ? ledger.lock_start : ledger.win_start;
        pick    = spread ? $urandom_range(0, 99) : $urandom_range(0, 54);
        if (pick < 25)
            stamp = stamp + $urandom_range(0, 3000);
        else if (pick < 45)
            stamp = stamp + span(step_us + 64'd2000);
        else if (pick < 55)
            stamp = ledger.last_fail + step_us + $urandom_range(0, 2000) - 64'd1000;
        else if (pick < 70)
            stamp = base + win - 64'd1 + $urandom_range(0, 2);
        else if (pick < 80)
            stamp = stamp + span(win << 1);
        else if (pick < 86)
            stamp = stamp - $urandom_range(0, 5000);
        else if (pick < 92)
            stamp = rand64();
        return stamp;
    endfunction

    task automatic send_event(input logic [1:0] cmd, input logic [TS_W-1:0] t);
        int unsigned gap;
        gap = (burst_left != 0) ? 0 : $urandom_range(0, tx_max);
        if (burst_left != 0)
            burst_left--;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        now_us   <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ledger.note_event(cmd, t);
        sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (ledger.due_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ledger.set_reg(idx, val);
    endtask

    // unused bits carry junk, and the spare indexes get writes that must be ignored
    task automatic configure(input logic [WIN_W-1:0] win, input logic [CNT_W-1:0] lim,
                             input logic [MS_W-1:0] s0, input logic [MS_W-1:0] s1,
                             input logic [MS_W-1:0] s2, input logic [MS_W-1:0] s3);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'(rand64());
        write_reg(REG_SPARE_A, junk);
        write_reg(REG_WINDOW, win);
        write_reg(REG_LIMIT, {junk[CFG_DATA_W-1:CNT_W], lim});
        write_reg(REG_STEP0, {junk[CFG_DATA_W-1:MS_W], s0});
        write_reg(REG_STEP0 + 3'd1, {junk[CFG_DATA_W-1:MS_W], s1});
        write_reg(REG_STEP0 + 3'd2, {junk[CFG_DATA_W-1:MS_W], s2});
        write_reg(REG_STEP0 + 3'd3, {junk[CFG_DATA_W-1:MS_W], s3});
        write_reg(REG_SPARE_B, ~junk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_setting(input int phase);
        case (phase)
            0: configure(WINDOW_RESET, LIMIT_RESET,
                         STEP_RESET[0], STEP_RESET[1], STEP_RESET[2], STEP_RESET[3]);
            1: configure(40'd20000, 16'd3, 32'd1, 32'd2, 32'd5, 32'd10);
            2: configure('1, 16'd1, '1, '1, '1, '1);
            3: configure(40'd1, 16'd2, '0, '0, '0, '0);
            4: configure('0, '0, 32'd7, '0, '1, 32'd3);
            5: configure(WIN_W'($urandom_range(1000, 50000000)), CNT_W'($urandom_range(1, 8)),
                         $urandom_range(0, 60000), $urandom_range(0, 60000),
                         $urandom_range(0, 60000), $urandom_range(0, 60000));
            6: configure(40'd5000000, '1, $urandom, $urandom, $urandom, $urandom);
            default: configure(WIN_W'(rand64()), CNT_W'($urandom),
                               $urandom, $urandom, $urandom, $urandom);
        endcase
    endtask

    // mostly failure bursts followed by checks, sometimes a success; the rest is noise
    task automatic episode();
        int unsigned n;
        int unsigned cap;
        tx_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
        rx_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
        if ($urandom_range(0, 9) < 7)
        begin
            cap = (ledger.fail_limit == 0 || ledger.fail_limit > 6) ? 6 : ledger.fail_limit + 1;
            n   = $urandom_range(1, cap);
            repeat (n)
            begin
                send_event(CMD_FAIL, next_stamp(1'b0));
                if ($urandom_range(0, 2) == 0)
                    send_event(CMD_CHECK, next_stamp(1'b1));
            end
            repeat ($urandom_range(1, 4))
                send_event(CMD_CHECK, next_stamp(1'b1));
            if ($urandom_range(0, 1) == 1)
                send_event(CMD_SUCCESS, next_stamp(1'b0));
        end
        else
            repeat ($urandom_range(1, 6))
                send_event(2'($urandom_range(CMD_CHECK, CMD_SPARE)), next_stamp(1'b1));
    endtask

    task automatic directed();
        logic [TS_W-1:0] w;
        w = TS_W'(WINDOW_RESET);
        send_event(CMD_CHECK, '0);
        // failure at time zero leaves no window open
        send_event(CMD_FAIL, '0);
        send_event(CMD_FAIL, 64'd1000);
        send_event(CMD_CHECK, 64'd500);
        send_event(CMD_FAIL, 64'd2000);
        send_event(CMD_FAIL, 64'd3000);
        send_event(CMD_FAIL, 64'd4000);
        send_event(CMD_FAIL, 64'd5000);
        // failure while locked moves the lock start
        send_event(CMD_FAIL, 64'd6000);
        send_event(CMD_CHECK, 64'd6000 + w - 64'd1);
        send_event(CMD_CHECK, 64'd6000 + w);
        // elapsed ms wraps past 32 bits
        send_event(CMD_FAIL, 64'd100);
        send_event(CMD_CHECK, 64'd100 + (64'd1 << 32) * US_PER_MS + 64'd5000);
        send_event(CMD_SPARE, 64'd200);
        send_event(CMD_SUCCESS, 64'd300);
        send_event(CMD_FAIL, '1);
        send_event(CMD_FAIL, 64'd5);
        send_event(CMD_CHECK, '1);
        send_event(CMD_SUCCESS, '1);
        settle();
        // zero window and zero limit
        configure('0, '0, '1, 32'd1, '0, 32'd2);
        send_event(CMD_FAIL, 64'd10);
        send_event(CMD_CHECK, 64'd10);
        send_event(CMD_FAIL, 64'd20);
        send_event(CMD_FAIL, 64'd20);
    endtask

    initial
    begin
        int          phase;
        int unsigned quota;
        bit          held;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            pick_setting(phase);
            quota = sent + ITEMS_PER_PHASE;
            held  = 1'b0;
            while (sent < quota)
            begin
                // long result stall while items keep coming back to back
                if ((phase == 1 || phase == 5) && !held && sent + 160 >= quota)
                begin
                    hold_asks++;
                    burst_left = HOLD_BURST;
                    held       = 1'b1;
                end
                episode();
            end
        end
        settle();
        if (ledger.due_verdicts.size() != 0)
            ledger.report("results still pending at end of run");
        if (ledger.faults == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
